>>> rtl/gif3d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gif3d_pkg
// Shared constants and the 2^(-2^-(k+1)) factor table for the 3-D Gaussian
// kernel evaluator.
// ----------------------------------------------------------------------------
package gif3d_pkg;

    localparam int unsigned GRID_SIZE = 64;
    localparam int unsigned COORD_W   = 6;
    localparam int unsigned D2_W      = 14;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned ARG_W     = 21;
    localparam int unsigned Y_W       = 22;

    localparam logic [30:0] LOG2E_Q30 = 31'h5C551D95;
    localparam logic [31:0] ARG_LIMIT = 32'h0020_0000;

    typedef enum logic [2:0] {
        REG_PEAK     = 3'd0,
        REG_RATE     = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_CENTER_Z = 3'd4
    } reg_index_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = value;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] pow2_factor(input int unsigned k);
        logic [63:0] c;
        c = 64'h0000_0000_8000_0000;
        for (int unsigned i = 0; i <= k; i++) begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/gaussian_impulse_field_3d_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_impulse_field_3d_unit
// Evaluates peak * exp(-d2 * rate) at one grid cell per cycle while m_ready does not stall it, Q16.16.
// ----------------------------------------------------------------------------
// throughput: one cell per cycle while m_ready does not stall it, set by the single fully pipelined
//   datapath (16 factor multiplier stages plus argument and scale stages)
// the whole pipeline holds while the result waits and m_ready is low
// reset clears valid bits and sets the configuration registers to their reset values
// ----------------------------------------------------------------------------
module gaussian_impulse_field_3d_unit
    import gif3d_pkg::*;
#(
    parameter int unsigned GRID_CELLS = GRID_SIZE
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [5:0]  s_cell_x,
    input  wire logic [5:0]  s_cell_y,
    input  wire logic [5:0]  s_cell_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_field_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned NM = FRAC_BITS;

    logic [31:0] peak_reg, rate_reg;
    logic [5:0]  cx_reg, cy_reg, cz_reg;

    logic        adv;

    // stage 0: captured cell
    logic        v0_reg;
    logic [5:0]  x0_reg, y0_reg, z0_reg;
    // stage 1: squared distance
    logic        v1_reg, z1_reg;
    logic [D2_W-1:0] d2_reg;
    // stage 2: argument
    logic        v2_reg, z2_reg;
    logic [ARG_W-1:0] a_reg;
    // stage 3: log2 domain
    logic        v3_reg, z3_reg;
    logic [4:0]  n3_reg;
    logic [FRAC_BITS-1:0] f3_reg;
    // factor stages
    logic        vm_reg [NM];
    logic        zm_reg [NM];
    logic [4:0]  nm_reg [NM];
    logic [FRAC_BITS-1:0] fm_reg [NM];
    logic [32:0] mm_reg [NM];
    logic [32:0] mm_next [NM];
    // scale stage
    logic        vp_reg, zp_reg;
    logic [4:0]  np_reg;
    logic [64:0] prod_reg;
    // output
    logic        vo_reg;
    logic [31:0] q_reg;

    function automatic logic [5:0] absdiff(input logic [5:0] a, input logic [5:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [5:0]  dx, dy, dz;
    logic [D2_W-1:0] d2_next;
    logic        oob_next;
    logic [45:0] a_full;
    logic [31:0] a_sat;
    logic [51:0] y_full;
    logic [Y_W-1:0] y_val;
    logic [33:0] sh;

    assign adv       = !vo_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = vo_reg;
    assign m_field_value = q_reg;

    always_comb begin
        dx = absdiff(x0_reg, cx_reg);
        dy = absdiff(y0_reg, cy_reg);
        dz = absdiff(z0_reg, cz_reg);
        d2_next = ({8'b0, dx} * {8'b0, dx}) + ({8'b0, dy} * {8'b0, dy})
                + ({8'b0, dz} * {8'b0, dz});
        oob_next = (32'(x0_reg) >= GRID_CELLS) || (32'(y0_reg) >= GRID_CELLS)
                || (32'(z0_reg) >= GRID_CELLS);
        a_full = {32'b0, d2_reg} * {14'b0, rate_reg};
        a_sat  = (a_full[45:32] != 14'd0) ? 32'hFFFF_FFFF : a_full[31:0];
        y_full = ({31'b0, a_reg} * {21'b0, LOG2E_Q30}) + 52'h2000_0000;
        y_val  = y_full[30 +: Y_W];
        for (int k = 0; k < NM; k++) begin
            logic [64:0] p;
            logic [32:0] src;
            logic [FRAC_BITS-1:0] fb;
            src = (k == 0) ? 33'h1_0000_0000 : mm_reg[k-1];
            fb  = (k == 0) ? f3_reg : fm_reg[k-1];
            p   = ({32'b0, src} * {33'b0, pow2_factor(k)}) + 65'h8000_0000;
            mm_next[k] = fb[FRAC_BITS-1-k] ? p[64:32] : src;
        end
        sh = 34'(prod_reg >> (7'd31 + {2'b0, np_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= 32'h0001_0000;
            rate_reg <= 32'h0001_0000;
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PEAK:     peak_reg <= cfg_data;
                REG_RATE:     rate_reg <= cfg_data;
                REG_CENTER_X: cx_reg   <= cfg_data[5:0];
                REG_CENTER_Y: cy_reg   <= cfg_data[5:0];
                REG_CENTER_Z: cz_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k < NM; k++) begin
                vm_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vm_reg[0] <= v3_reg;
            for (int k = 1; k < NM; k++) begin
                vm_reg[k] <= vm_reg[k-1];
            end
            vp_reg <= vm_reg[NM-1];
            vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg <= s_cell_x;
            y0_reg <= s_cell_y;
            z0_reg <= s_cell_z;
            d2_reg <= d2_next;
            z1_reg <= oob_next;
            a_reg  <= a_sat[ARG_W-1:0];
            z2_reg <= z1_reg || (a_sat >= ARG_LIMIT);
            n3_reg <= y_val[20:16];
            f3_reg <= y_val[15:0];
            z3_reg <= z2_reg || y_val[21];
            zm_reg[0] <= z3_reg;
            nm_reg[0] <= n3_reg;
            fm_reg[0] <= f3_reg;
            mm_reg[0] <= mm_next[0];
            for (int k = 1; k < NM; k++) begin
                zm_reg[k] <= zm_reg[k-1];
                nm_reg[k] <= nm_reg[k-1];
                fm_reg[k] <= fm_reg[k-1];
                mm_reg[k] <= mm_next[k];
            end
            zp_reg   <= zm_reg[NM-1];
            np_reg   <= nm_reg[NM-1];
            prod_reg <= {33'b0, peak_reg} * {32'b0, mm_reg[NM-1]};
            q_reg    <= zp_reg ? 32'd0 : 32'(sh[33:1] + {32'b0, sh[0]});
        end
    end

endmodule

`default_nettype wire
